[sv/timeout_message_table_top_defines.svh]
// Assertion helpers for the timeout message table RTL
`ifndef TIMEOUT_MESSAGE_TABLE_TOP_DEFINES_SVH
`define TIMEOUT_MESSAGE_TABLE_TOP_DEFINES_SVH

// cond holds at every clock edge out of reset
`define TMT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define TMT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define TMT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tmt_pkg.sv]
package tmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int HANDLE_W        = 8;
    localparam int DELAY_W         = 16;
    localparam int REM_W           = 17;
    localparam int TPS_W           = 16;
    localparam int SEC_W           = 8;
    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [HANDLE_W-1:0]   handle;
        logic [DELAY_W-1:0]    delay;
    } cmd_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [REM_W-1:0]    rem;
    } entry_t;

    typedef struct packed {
        logic                expired_valid;
        logic [HANDLE_W-1:0] expired_handle;
        logic                insert_rejected;
        logic [SEC_W-1:0]    seconds_value;
        logic                last_result;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WALK   = 2'd1,
        ST_FINISH = 2'd2
    } back_state_t;

endpackage

[sv/tmt_ram.sv]
module tmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/tmt_front.sv]
module tmt_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [tmt_pkg::HANDLE_W-1:0]        s_message_handle,
    input  logic [tmt_pkg::DELAY_W-1:0]         s_delay_ticks,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output tmt_pkg::cmd_t                       cmd
);

    tmt_pkg::cmd_t slot_reg [0:1];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          push, pop;
    tmt_pkg::cmd_t in_cmd;

    always_comb begin
        in_cmd.kind   = s_action ? tmt_pkg::CMD_INSERT : tmt_pkg::CMD_TICK;
        in_cmd.handle = s_message_handle;
        in_cmd.delay  = s_delay_ticks;
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[sv/tmt_back.sv]
`include "timeout_message_table_top_defines.svh"

module tmt_back #(
    parameter int TABLE_DEPTH = tmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tmt_pkg::TPS_W-1:0]     cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  tmt_pkg::cmd_t                 cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tmt_pkg::result_t              result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = tmt_pkg::RES_CNT_W;
    localparam int EW = $bits(tmt_pkg::entry_t);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [NW-1:0] MAX_C   = NW'(tmt_pkg::MAX_RESULTS);

    tmt_pkg::back_state_t state_reg, state_next;

    logic [tmt_pkg::TPS_W-1:0]    tps_reg, tps_next;
    logic [tmt_pkg::TPS_W-1:0]    tick_reg, tick_next, tick_inc;
    logic [tmt_pkg::SEC_W-1:0]    sec_reg, sec_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                idx_reg, idx_next, idx_inc;
    logic [CW-1:0]                keep_reg, keep_next;
    logic [NW-1:0]                n_reg, n_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [tmt_pkg::HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    logic                         out_valid_reg;
    tmt_pkg::result_t             out_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    tmt_pkg::entry_t  ram_wdata, ram_q;
    logic [EW-1:0]    ram_rdata;

    logic             out_free, push;
    tmt_pkg::result_t push_res;
    logic             full, expired, emit, step_ok;

    tmt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_q    = tmt_pkg::entry_t'(ram_rdata);
    assign out_free = !out_valid_reg || m_ready;
    assign full     = (count_reg == DEPTH_C);
    assign idx_inc  = idx_reg + CW'(1);
    assign tick_inc = tick_reg + tmt_pkg::TPS_W'(1);
    assign expired  = (ram_q.rem <= tmt_pkg::REM_W'(1));
    assign emit     = expired && (n_reg < MAX_C);
    assign step_ok  = !(emit && pend_valid_reg) || out_free;
    assign tps_next = cfg_we ? cfg_wdata : tps_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmt_pkg::ST_IDLE: begin
                if (cmd_valid && cmd.kind == tmt_pkg::CMD_TICK) begin
                    state_next = (count_reg == '0) ? tmt_pkg::ST_FINISH : tmt_pkg::ST_WALK;
                end
            end
            tmt_pkg::ST_WALK: begin
                if (step_ok && idx_inc == count_reg) begin
                    state_next = tmt_pkg::ST_FINISH;
                end
            end
            tmt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = tmt_pkg::ST_IDLE;
                end
            end
            default: state_next = tmt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        tick_next        = tick_reg;
        sec_next         = sec_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        keep_next        = keep_reg;
        n_next           = n_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        cmd_ready        = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = keep_reg[AW-1:0];
        ram_wdata        = ram_q;
        ram_raddr        = idx_reg[AW-1:0];
        push             = 1'b0;
        push_res.expired_valid   = 1'b0;
        push_res.expired_handle  = '0;
        push_res.insert_rejected = 1'b0;
        push_res.seconds_value   = sec_reg;
        push_res.last_result     = 1'b0;
        unique case (state_reg)
            tmt_pkg::ST_IDLE: begin
                ram_raddr = '0;
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        tmt_pkg::CMD_INSERT: begin
                            if (out_free) begin
                                cmd_ready                = 1'b1;
                                push                     = 1'b1;
                                push_res.insert_rejected = full;
                                push_res.last_result     = 1'b1;
                                if (!full) begin
                                    ram_we           = 1'b1;
                                    ram_waddr        = count_reg[AW-1:0];
                                    ram_wdata.handle = cmd.handle;
                                    ram_wdata.rem    = {1'b0, cmd.delay};
                                    count_next       = count_reg + CW'(1);
                                end
                            end
                        end
                        tmt_pkg::CMD_TICK: begin
                            cmd_ready = 1'b1;
                            if (tick_inc >= tps_reg) begin
                                tick_next = '0;
                                sec_next  = sec_reg + tmt_pkg::SEC_W'(1);
                            end else begin
                                tick_next = tick_inc;
                            end
                            idx_next        = '0;
                            keep_next       = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            tmt_pkg::ST_WALK: begin
                if (step_ok) begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                    if (emit) begin
                        if (pend_valid_reg) begin
                            push                    = 1'b1;
                            push_res.expired_valid  = 1'b1;
                            push_res.expired_handle = pend_handle_reg;
                        end
                        pend_valid_next  = 1'b1;
                        pend_handle_next = ram_q.handle;
                        n_next           = n_reg + NW'(1);
                    end else begin
                        ram_we           = 1'b1;
                        ram_wdata.handle = ram_q.handle;
                        ram_wdata.rem    = expired ? tmt_pkg::REM_W'(1)
                                                   : ram_q.rem - tmt_pkg::REM_W'(1);
                        keep_next        = keep_reg + CW'(1);
                    end
                end
            end
            tmt_pkg::ST_FINISH: begin
                if (out_free) begin
                    push                    = 1'b1;
                    push_res.expired_valid  = pend_valid_reg;
                    push_res.expired_handle = pend_valid_reg ? pend_handle_reg : '0;
                    push_res.last_result    = 1'b1;
                    count_next              = keep_reg;
                    pend_valid_next         = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tmt_pkg::ST_IDLE;
            tps_reg        <= tmt_pkg::TPS_RESET;
            tick_reg       <= '0;
            sec_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tps_reg        <= tps_next;
            tick_reg       <= tick_next;
            sec_reg        <= sec_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_handle_reg <= pend_handle_next;
        if (push) begin
            out_reg <= push_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

    `TMT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_C,
        "entry count beyond table depth")
    `TMT_ASSERT_IMPLY(a_keep_behind, aclk, aresetn, state_reg == tmt_pkg::ST_WALK,
        keep_reg <= idx_reg && idx_reg < count_reg, "compaction write ahead of walk")
    `TMT_ASSERT_IMPLY(a_pend_count, aclk, aresetn, state_reg != tmt_pkg::ST_IDLE,
        pend_valid_reg == (n_reg != '0) && n_reg <= MAX_C, "held beat out of step with count")
    `TMT_ASSERT_NEXT(a_insert_grows, aclk, aresetn,
        cmd_valid && cmd_ready && cmd.kind == tmt_pkg::CMD_INSERT && !full,
        count_reg == $past(count_reg) + CW'(1), "insert did not grow the table")

endmodule

[sv/timeout_message_table_top.sv]
// Timeout message table.
// Input channel (s_valid/s_ready): s_action 1 inserts s_message_handle with
// s_delay_ticks remaining; s_action 0 is one timer tick. Result channel
// (m_valid/m_ready): one beat per insert (m_insert_rejected set when the table
// is full), and per tick one beat for each expired handle in table order, or a
// single beat with m_expired_valid low when nothing expires. m_last_result
// marks the final beat of an item; m_seconds_value is the seconds count.
// cfg_we/cfg_wdata set the tick period of the seconds count (reset 1000).
// Items pass a two-beat queue before the table engine, then an output register.
// Insert: one item per cycle while the result receiver keeps up.
// Tick: the table walk visits one stored entry per cycle unless a held expired
// beat waits on the receiver; the table RAM has one read and one write port.
// Reset empties the table and clears the tick and seconds counts.
// A stalled receiver holds the engine; the queue then fills and s_ready drops.
module timeout_message_table_top #(
    parameter int TABLE_DEPTH = tmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tmt_pkg::TPS_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [tmt_pkg::HANDLE_W-1:0]   s_message_handle,
    input  logic [tmt_pkg::DELAY_W-1:0]    s_delay_ticks,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_expired_valid,
    output logic [tmt_pkg::HANDLE_W-1:0]   m_expired_handle,
    output logic                           m_insert_rejected,
    output logic [tmt_pkg::SEC_W-1:0]      m_seconds_value,
    output logic                           m_last_result
);

    logic             cmd_valid, cmd_ready;
    tmt_pkg::cmd_t    cmd;
    tmt_pkg::result_t result;

    tmt_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_message_handle (s_message_handle),
        .s_delay_ticks    (s_delay_ticks),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd)
    );

    tmt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_expired_valid   = result.expired_valid;
    assign m_expired_handle  = result.expired_handle;
    assign m_insert_rejected = result.insert_rejected;
    assign m_seconds_value   = result.seconds_value;
    assign m_last_result     = result.last_result;

endmodule

[dv/tb_top.sv]
module tb_top;

    localparam int TBL_DEPTH = tmt_pkg::TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [tmt_pkg::TPS_W-1:0]    cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_action = 1'b0;
    logic [tmt_pkg::HANDLE_W-1:0] s_message_handle = '0;
    logic [tmt_pkg::DELAY_W-1:0]  s_delay_ticks = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_expired_valid;
    logic [tmt_pkg::HANDLE_W-1:0] m_expired_handle;
    logic                         m_insert_rejected;
    logic [tmt_pkg::SEC_W-1:0]    m_seconds_value;
    logic                         m_last_result;

    timeout_message_table_top #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_message_handle  (s_message_handle),
        .s_delay_ticks     (s_delay_ticks),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_expired_valid   (m_expired_valid),
        .m_expired_handle  (m_expired_handle),
        .m_insert_rejected (m_insert_rejected),
        .m_seconds_value   (m_seconds_value),
        .m_last_result     (m_last_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // timer table as the block should hold it
    logic [tmt_pkg::HANDLE_W-1:0] tbl_handle [TBL_DEPTH];
    logic [tmt_pkg::REM_W-1:0]    tbl_left [TBL_DEPTH];
    int                           tbl_count = 0;
    logic [tmt_pkg::TPS_W-1:0]    sub_ticks = '0;
    logic [tmt_pkg::SEC_W-1:0]    secs = '0;
    logic [tmt_pkg::TPS_W-1:0]    period_model = tmt_pkg::TPS_RESET;

    tmt_pkg::cmd_t    pending_cmds [$];
    tmt_pkg::result_t due_results [$];
    tmt_pkg::cmd_t    next_cmd;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit tx_pause = 1'b0;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int err_cnt = 0;

    task automatic predict_item(input tmt_pkg::cmd_kind_t kind,
                                input logic [tmt_pkg::HANDLE_W-1:0] handle,
                                input logic [tmt_pkg::DELAY_W-1:0] delay);
        tmt_pkg::result_t r;
        int keep;
        int n;
        logic [tmt_pkg::REM_W-1:0] rem;
        r = '0;
        r.last_result = 1'b1;
        if (kind == tmt_pkg::CMD_INSERT) begin
            if (tbl_count < TBL_DEPTH) begin
                tbl_handle[tbl_count] = handle;
                tbl_left[tbl_count] = {1'b0, delay};
                tbl_count++;
            end else begin
                r.insert_rejected = 1'b1;
            end
            r.seconds_value = secs;
            due_results.push_back(r);
        end else begin
            sub_ticks = sub_ticks + tmt_pkg::TPS_W'(1);
            if (sub_ticks >= period_model) begin
                secs = secs + tmt_pkg::SEC_W'(1);
                sub_ticks = '0;
            end
            keep = 0;
            n = 0;
            for (int i = 0; i < tbl_count; i++) begin
                rem = tbl_left[i];
                if (rem <= tmt_pkg::REM_W'(1)) begin
                    if (n < tmt_pkg::MAX_RESULTS) begin
                        r = '0;
                        r.expired_valid = 1'b1;
                        r.expired_handle = tbl_handle[i];
                        r.seconds_value = secs;
                        due_results.push_back(r);
                        n++;
                        continue;
                    end
                    rem = tmt_pkg::REM_W'(1);
                end else begin
                    rem = rem - tmt_pkg::REM_W'(1);
                end
                tbl_handle[keep] = tbl_handle[i];
                tbl_left[keep] = rem;
                keep++;
            end
            tbl_count = keep;
            if (n == 0) begin
                r = '0;
                r.seconds_value = secs;
                r.last_result = 1'b1;
                due_results.push_back(r);
            end else begin
                r = due_results.pop_back();
                r.last_result = 1'b1;
                due_results.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // input beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_item(tmt_pkg::cmd_kind_t'(s_action), s_message_handle,
                             s_delay_ticks);
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && !tx_pause &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_action <= next_cmd.kind;
                    s_message_handle <= next_cmd.handle;
                    s_delay_ticks <= next_cmd.delay;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off
    always @(posedge aclk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result beats
    always @(posedge aclk) begin
        tmt_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = due_results.pop_front();
                    check_field("expired_valid", {7'd0, m_expired_valid},
                                {7'd0, want.expired_valid});
                    check_field("expired_handle", m_expired_handle, want.expired_handle);
                    check_field("insert_rejected", {7'd0, m_insert_rejected},
                                {7'd0, want.insert_rejected});
                    check_field("seconds_value", m_seconds_value, want.seconds_value);
                    check_field("last_result", {7'd0, m_last_result},
                                {7'd0, want.last_result});
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_cmd(input tmt_pkg::cmd_kind_t kind, input int handle,
                            input int delay);
        tmt_pkg::cmd_t c;
        c.kind = kind;
        c.handle = handle[tmt_pkg::HANDLE_W-1:0];
        c.delay = delay[tmt_pkg::DELAY_W-1:0];
        pending_cmds.push_back(c);
    endtask

    task automatic add_random(input int count);
        int made;
        int blen;
        int bdel;
        int sel;
        int delay;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                // burst of equal-delay inserts, then enough ticks to drain it
                blen = $urandom_range(16, 4);
                bdel = $urandom_range(3);
                repeat (blen) push_cmd(tmt_pkg::CMD_INSERT, $urandom_range(255), bdel);
                repeat (bdel + 1)
                    push_cmd(tmt_pkg::CMD_TICK, $urandom_range(255), $urandom_range(65535));
                made += blen + bdel + 1;
            end else begin
                sel = $urandom_range(99);
                if (sel < 70)
                    delay = $urandom_range(8);
                else if (sel < 85)
                    delay = $urandom_range(40);
                else if (sel < 95)
                    delay = $urandom_range(65535);
                else
                    delay = sel[0] ? 65535 : 0;
                push_cmd(($urandom_range(99) < 45) ? tmt_pkg::CMD_TICK : tmt_pkg::CMD_INSERT,
                         $urandom_range(255), delay);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
        repeat (TBL_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic write_period(input int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[tmt_pkg::TPS_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        period_model = value[tmt_pkg::TPS_W-1:0];
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the table, overflow it, expire all sixteen on one tick
        tx_idle_pct = 23;
        rx_idle_pct = 49;
        push_cmd(tmt_pkg::CMD_INSERT, 0, 0);
        push_cmd(tmt_pkg::CMD_INSERT, 255, 1);
        for (int i = 1; i <= 14; i++)
            push_cmd(tmt_pkg::CMD_INSERT, i * 17, 1);
        push_cmd(tmt_pkg::CMD_INSERT, 255, 65535);
        push_cmd(tmt_pkg::CMD_TICK, 0, 0);
        push_cmd(tmt_pkg::CMD_INSERT, 8'h5A, 65535);
        push_cmd(tmt_pkg::CMD_INSERT, 8'hA5, 2);
        push_cmd(tmt_pkg::CMD_TICK, 255, 65535);
        push_cmd(tmt_pkg::CMD_TICK, 0, 0);
        wait_idle();

        // long receiver stall while the sender keeps offering
        write_period(65535);
        add_random(80);
        hold_req_cnt++;
        wait_idle();

        // period below the running count; sender drains the block mid-phase
        write_period(3);
        tx_idle_pct = 49;
        rx_idle_pct = 23;
        add_random(80);
        while (pending_cmds.size() > 40)
            @(posedge aclk);
        tx_pause = 1'b1;
        while (s_valid || due_results.size() != 0)
            @(posedge aclk);
        tx_pause = 1'b0;
        wait_idle();

        write_period(1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random(70);
        wait_idle();

        write_period(0);
        add_random(20);
        wait_idle();

        if (err_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
